// ===== hdl/gbns_pkg.sv =====
// Shared constants and types for the go-back-n sender window block.
package gbns_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_SEQ_BITS   = 32;

    localparam int KIND_W     = 2;
    localparam int ACK_W      = 32;
    localparam int LEN_W      = 8;
    localparam int WS_W       = 7;
    localparam int TO_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

    localparam logic [WS_W-1:0] WINDOW_SIZE_RESET   = 7'd64;
    localparam logic [TO_W-1:0] TIMEOUT_TICKS_RESET = 16'd5000;
    localparam logic [TO_W-1:0] IDLE_MAX            = 16'hFFFF;

    localparam logic [LEN_W-1:0] ACK_LEN_NORMAL = 8'd6;
    localparam logic [LEN_W-1:0] ACK_LEN_END    = 8'd0;

    localparam logic [1:0] DUP_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PEND1,
        S_PEND2,
        S_WIN,
        S_EMIT
    } t_state;

endpackage

// ===== hdl/gbns_if.sv =====
// Valid/ready channel interfaces for configuration, input items and result items.
interface gbns_cfg_if
    import gbns_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface gbns_in_if
    import gbns_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ACK_W-1:0]  ack_number;
    logic [LEN_W-1:0]  ack_length;

    modport source (output valid, kind, ack_number, ack_length, input ready);
    modport sink   (input valid, kind, ack_number, ack_length, output ready);
endinterface

interface gbns_out_if
    import gbns_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             send_valid;
    logic [ACK_W-1:0] send_sequence;
    logic             is_retransmit;
    logic             offer_accepted;
    logic             finished;
    logic             last_result;

    modport source (output valid, send_valid, send_sequence, is_retransmit,
                    offer_accepted, finished, last_result, input ready);
    modport sink   (input valid, send_valid, send_sequence, is_retransmit,
                    offer_accepted, finished, last_result, output ready);
endinterface

// ===== hdl/go_back_n_sender_window.sv =====
// Go-back-n sender window control: sequencer around one shared sequence subtractor.
//
//   Channel   Dir   Carries                                        Handshake
//   i_cfg     in    index, data (window_size, timeout_ticks)       valid/ready, always ready
//   i_in      in    kind, ack_number, ack_length                   valid/ready
//   o_out     out   send_valid, send_sequence, is_retransmit,      valid/ready
//                   offer_accepted, finished, last_result
//
// An offer passes through the evaluate and emit steps, and its result enters the output register.
// A tick is only evaluated, or on a timeout passes through the window step and resends any
// outstanding packets from the emit step. An ACK that sends nothing is evaluated and emitted, passing
// through the pending steps when it moves forward; a fast resend takes the window step, and a forward
// ACK resends its pending packets after the pending steps. The shared subtractor is used once per
// sequencer step, and the emit step puts one result per cycle in the output register unless it stalls.
// Reset is synchronous, active low, and restores the register defaults and a clear window.
// A stalled output holds the emit step; the next input is taken once the sequencer is idle,
// even while the final result still waits in the output register.
module go_back_n_sender_window
    import gbns_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = DEF_SEQ_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbns_cfg_if.sink      i_cfg,
    gbns_in_if.sink       i_in,
    gbns_out_if.source    o_out
);

    localparam int W_BITS = $clog2(MAX_WINDOW + 1);
    localparam logic [W_BITS-1:0] W_MAX = W_BITS'(MAX_WINDOW);

    t_state r_state, n_state;

    logic [WS_W-1:0]     r_ws, n_ws;
    logic [TO_W-1:0]     r_to, n_to;
    logic [SEQ_BITS-1:0] r_base, n_base;
    logic [SEQ_BITS-1:0] r_next, n_next;
    logic [SEQ_BITS-1:0] r_resend, n_resend;
    logic [1:0]          r_dup, n_dup;
    logic [SEQ_BITS-1:0] r_last_dup, n_last_dup;
    logic [TO_W-1:0]     r_idle, n_idle;
    logic                r_done, n_done;

    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [SEQ_BITS-1:0] r_ack, n_ack;
    logic [LEN_W-1:0]    r_len, n_len;

    logic [SEQ_BITS-1:0] r_seq, n_seq;
    logic [W_BITS-1:0]   r_cnt, n_cnt;
    logic                r_single, n_single;
    logic                r_s_valid, n_s_valid;
    logic                r_s_acc, n_s_acc;

    logic                r_o_valid, n_o_valid;
    logic                r_o_send_valid, n_o_send_valid;
    logic [ACK_W-1:0]    r_o_seq, n_o_seq;
    logic                r_o_retx, n_o_retx;
    logic                r_o_acc, n_o_acc;
    logic                r_o_fin, n_o_fin;
    logic                r_o_last, n_o_last;

    // Shared serial-distance unit: a - b - borrow over SEQ_BITS.
    logic [SEQ_BITS-1:0] sub_a, sub_b, diff;
    logic                sub_borrow;
    logic                diff_neg, diff_pos, diff_lt_w, diff_gt_w;

    logic [W_BITS-1:0]   w_eff;
    logic [SEQ_BITS-1:0] w_ext;
    logic [TO_W-1:0]     lim, idle_new;
    logic                timeout;
    logic [1:0]          dup_new;
    logic                dup_hit;
    logic                offer_ok;
    logic [W_BITS-1:0]   room, n_pend;
    logic [SEQ_BITS-1:0] ack_plus1, seq_plus1;
    logic                in_fire, cfg_fire, out_free, emit_last;
    logic                ack_normal;

    assign in_fire   = i_in.valid && i_in.ready;
    assign cfg_fire  = i_cfg.valid && i_cfg.ready;
    assign out_free  = !r_o_valid || o_out.ready;
    assign emit_last = r_single || (r_cnt == W_BITS'(1));

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    assign o_out.valid          = r_o_valid;
    assign o_out.send_valid     = r_o_send_valid;
    assign o_out.send_sequence  = r_o_seq;
    assign o_out.is_retransmit  = r_o_retx;
    assign o_out.offer_accepted = r_o_acc;
    assign o_out.finished       = r_o_fin;
    assign o_out.last_result    = r_o_last;

    // A window register of zero acts as one, and values above the maximum are clipped.
    always_comb begin
        if (r_ws == '0) begin
            w_eff = W_BITS'(1);
        end else if (r_ws > WS_W'(MAX_WINDOW)) begin
            w_eff = W_MAX;
        end else begin
            w_eff = W_BITS'(r_ws);
        end
    end
    assign w_ext = SEQ_BITS'(w_eff);

    always_comb begin
        sub_a      = r_next;
        sub_b      = r_base;
        sub_borrow = 1'b0;
        unique case (r_state)
            S_EVAL: begin
                if (r_kind == KIND_ACK) begin
                    sub_a = r_ack;
                end
            end
            S_PEND1: begin
                sub_b = r_resend;
            end
            S_PEND2: begin
                sub_a      = r_resend;
                sub_borrow = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign diff      = sub_a - sub_b - SEQ_BITS'(sub_borrow);
    assign diff_neg  = diff[SEQ_BITS-1];
    assign diff_pos  = !diff_neg && (diff != '0);
    assign diff_lt_w = diff_neg || (diff < w_ext);
    assign diff_gt_w = !diff_neg && (diff > w_ext);

    assign lim      = (r_to == '0) ? TO_W'(1) : r_to;
    assign idle_new = (r_idle == IDLE_MAX) ? r_idle : r_idle + TO_W'(1);
    assign timeout  = (idle_new >= lim);

    assign dup_new = ((r_ack != r_last_dup) && (r_dup < DUP_LIMIT)) ? r_dup + 2'd1 : r_dup;
    assign dup_hit = (dup_new == DUP_LIMIT);

    assign offer_ok   = !r_done && (r_resend == r_next) && diff_lt_w;
    assign ack_normal = !r_done && (r_len == ACK_LEN_NORMAL);

    // Room left for a pending resend, clamped to 0..window.
    always_comb begin
        if (diff_neg) begin
            room = w_eff;
        end else if (diff >= w_ext) begin
            room = '0;
        end else begin
            room = w_eff - diff[W_BITS-1:0];
        end
    end
    assign n_pend = (r_cnt < room) ? r_cnt : room;

    assign ack_plus1 = r_ack + SEQ_BITS'(1);
    assign seq_plus1 = r_seq + SEQ_BITS'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                case (r_kind)
                    KIND_OFFER: n_state = S_EMIT;
                    KIND_TICK:  n_state = (!r_done && timeout) ? S_WIN : S_IDLE;
                    KIND_ACK: begin
                        if (ack_normal) begin
                            if (diff_neg) begin
                                n_state = dup_hit ? S_WIN : S_EMIT;
                            end else begin
                                n_state = S_PEND1;
                            end
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PEND1: begin
                n_state = diff_pos ? S_PEND2 : S_EMIT;
            end
            S_PEND2: begin
                n_state = S_EMIT;
            end
            S_WIN: begin
                n_state = (diff_pos || (r_kind == KIND_ACK)) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ws       = r_ws;
        n_to       = r_to;
        n_base     = r_base;
        n_next     = r_next;
        n_resend   = r_resend;
        n_dup      = r_dup;
        n_last_dup = r_last_dup;
        n_idle     = r_idle;
        n_done     = r_done;
        n_kind     = r_kind;
        n_ack      = r_ack;
        n_len      = r_len;
        n_seq      = r_seq;
        n_cnt      = r_cnt;
        n_single   = r_single;
        n_s_valid  = r_s_valid;
        n_s_acc    = r_s_acc;

        n_o_valid      = r_o_valid && !o_out.ready;
        n_o_send_valid = r_o_send_valid;
        n_o_seq        = r_o_seq;
        n_o_retx       = r_o_retx;
        n_o_acc        = r_o_acc;
        n_o_fin        = r_o_fin;
        n_o_last       = r_o_last;

        if (cfg_fire) begin
            unique case (i_cfg.index)
                CFG_WINDOW_SIZE:   n_ws = i_cfg.data[WS_W-1:0];
                CFG_TIMEOUT_TICKS: n_to = i_cfg.data[TO_W-1:0];
                default: begin
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind = i_in.kind;
                    n_ack  = i_in.ack_number[SEQ_BITS-1:0];
                    n_len  = i_in.ack_length;
                end
            end
            S_EVAL: begin
                case (r_kind)
                    KIND_OFFER: begin
                        n_single  = 1'b1;
                        n_s_valid = offer_ok;
                        n_s_acc   = offer_ok;
                        n_seq     = r_next;
                        if (offer_ok) begin
                            n_next   = r_next + SEQ_BITS'(1);
                            n_resend = r_resend + SEQ_BITS'(1);
                            if (r_next == r_base) begin
                                n_idle = '0;
                            end
                        end
                    end
                    KIND_TICK: begin
                        if (!r_done) begin
                            n_idle = idle_new;
                        end
                    end
                    KIND_ACK: begin
                        if (ack_normal) begin
                            if (diff_neg) begin
                                n_dup = dup_new;
                                if (dup_hit) begin
                                    n_last_dup = r_ack;
                                end else begin
                                    n_single  = 1'b1;
                                    n_s_valid = 1'b0;
                                    n_s_acc   = 1'b0;
                                    n_base    = ack_plus1;
                                    n_idle    = '0;
                                end
                            end
                        end else begin
                            if (!r_done && (r_len == ACK_LEN_END)) begin
                                n_done = 1'b1;
                            end
                            n_single  = 1'b1;
                            n_s_valid = 1'b0;
                            n_s_acc   = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PEND1: begin
                if (diff_pos) begin
                    n_cnt = diff_gt_w ? w_eff : diff[W_BITS-1:0];
                end else begin
                    n_single  = 1'b1;
                    n_s_valid = 1'b0;
                    n_s_acc   = 1'b0;
                    n_base    = ack_plus1;
                    n_idle    = '0;
                end
            end
            S_PEND2: begin
                n_base = ack_plus1;
                n_idle = '0;
                if (n_pend == '0) begin
                    n_single  = 1'b1;
                    n_s_valid = 1'b0;
                    n_s_acc   = 1'b0;
                end else begin
                    n_single = 1'b0;
                    n_cnt    = n_pend;
                    n_seq    = r_resend;
                end
            end
            S_WIN: begin
                // The resend point follows the emitted sends; with nothing to send it
                // snaps to the next new sequence number.
                n_dup  = '0;
                n_idle = '0;
                if (r_kind == KIND_ACK) begin
                    n_base = ack_plus1;
                end
                if (diff_pos) begin
                    n_single = 1'b0;
                    n_cnt    = diff_gt_w ? w_eff : diff[W_BITS-1:0];
                    n_seq    = r_base;
                end else begin
                    n_resend  = r_next;
                    n_single  = 1'b1;
                    n_s_valid = 1'b0;
                    n_s_acc   = 1'b0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_fin   = r_done;
                    n_o_last  = emit_last;
                    if (r_single) begin
                        n_o_send_valid = r_s_valid;
                        n_o_seq        = r_s_valid ? ACK_W'(r_seq) : '0;
                        n_o_retx       = 1'b0;
                        n_o_acc        = r_s_acc;
                    end else begin
                        n_o_send_valid = 1'b1;
                        n_o_seq        = ACK_W'(r_seq);
                        n_o_retx       = 1'b1;
                        n_o_acc        = 1'b0;
                        n_seq          = seq_plus1;
                        n_resend       = seq_plus1;
                        n_cnt          = r_cnt - W_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ws       <= WINDOW_SIZE_RESET;
            r_to       <= TIMEOUT_TICKS_RESET;
            r_base     <= '0;
            r_next     <= '0;
            r_resend   <= '0;
            r_dup      <= '0;
            r_last_dup <= '0;
            r_idle     <= '0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_single   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ws       <= n_ws;
            r_to       <= n_to;
            r_base     <= n_base;
            r_next     <= n_next;
            r_resend   <= n_resend;
            r_dup      <= n_dup;
            r_last_dup <= n_last_dup;
            r_idle     <= n_idle;
            r_done     <= n_done;
            r_cnt      <= n_cnt;
            r_single   <= n_single;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind         <= n_kind;
        r_ack          <= n_ack;
        r_len          <= n_len;
        r_seq          <= n_seq;
        r_s_valid      <= n_s_valid;
        r_s_acc        <= n_s_acc;
        r_o_send_valid <= n_o_send_valid;
        r_o_seq        <= n_o_seq;
        r_o_retx       <= n_o_retx;
        r_o_acc        <= n_o_acc;
        r_o_fin        <= n_o_fin;
        r_o_last       <= n_o_last;
    end

    a_emit_count_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_single) |-> (r_cnt != '0))
        else $error("resend burst entered with an empty count");

    a_count_in_window : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= W_MAX))
        else $error("resend count exceeds the maximum window");

    a_done_sticks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("finished flag cleared without reset");

    a_last_returns_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && emit_last) |=> (r_state == S_IDLE && r_o_last))
        else $error("final result did not return the sequencer to idle");

    a_dup_cleared_by_resend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIN) |=> (r_dup == '0))
        else $error("duplicate count survived a window resend");

endmodule
